// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the frame level selector.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Check that a trigger implies a condition in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");

// Check that a trigger implies a condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/cfls_pkg.sv
// Shared types, constants and CRC helpers of the frame level selector.
// No dependencies; used by the channel interfaces and all modules.
`default_nettype none

package cfls_pkg;

   localparam int unsigned ByteWidth = 8;

   // CRC-8 parameters: polynomial, top bit and initial value
   localparam logic [ByteWidth-1:0] CrcPoly = 8'h07;
   localparam logic [ByteWidth-1:0] CrcTop  = 8'h80;
   localparam logic [ByteWidth-1:0] CrcInit = 8'h00;

   // status bit that selects the second pedal level
   localparam logic [ByteWidth-1:0] SelectTwoMask = 8'h02;

   // register reset values
   localparam logic [ByteWidth-1:0] HeaderReset = 8'h00;
   localparam logic [ByteWidth-1:0] OnMaskReset = 8'h01;

   // register map
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrAddrWidth = 3;

   typedef enum logic {
      REG_EXPECTED_HEADER = 1'b0,
      REG_ON_BIT_MASK     = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [ByteWidth-1:0] frame_header;
      logic [ByteWidth-1:0] status_byte;
      logic [ByteWidth-1:0] level_one;
      logic [ByteWidth-1:0] level_two;
      logic [ByteWidth-1:0] check_byte;
      logic [ByteWidth-1:0] local_level;
   } req_word_type;

   typedef struct packed {
      logic                 link_ok;
      logic                 mute;
      logic                 pot_write;
      logic [ByteWidth-1:0] pot_level;
   } rsp_word_type;

   typedef struct packed {
      logic [ByteWidth-1:0] expected_header;
      logic [ByteWidth-1:0] on_bit_mask;
   } cfg_type;

   typedef struct packed {
      logic [ByteWidth-1:0] last_local;
      logic [ByteWidth-1:0] last_pedal_one;
      logic [ByteWidth-1:0] last_pedal_two;
   } level_state_type;

   // Shift one byte through the CRC register, MSB first.
   function automatic logic [ByteWidth-1:0] crc_byte(input logic [ByteWidth-1:0] crc,
                                                     input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] r;
      r = crc ^ b;
      for (int k = 0; k < ByteWidth; k++) begin
         if ((r & CrcTop) != '0) begin
            r = (r << 1) ^ CrcPoly;
         end else begin
            r = r << 1;
         end
      end
      return r;
   endfunction

   // CRC over three bytes. With a zero start the CRC is linear, so each
   // byte contributes on its own and the terms are combined by xor.
   function automatic logic [ByteWidth-1:0] crc_three(input logic [ByteWidth-1:0] b0,
                                                      input logic [ByteWidth-1:0] b1,
                                                      input logic [ByteWidth-1:0] b2);
      logic [ByteWidth-1:0] t0;
      logic [ByteWidth-1:0] t1;
      logic [ByteWidth-1:0] t2;
      t0 = crc_byte(crc_byte(crc_byte(CrcInit, b0), CrcInit), CrcInit);
      t1 = crc_byte(crc_byte(CrcInit, b1), CrcInit);
      t2 = crc_byte(CrcInit, b2);
      return t0 ^ t1 ^ t2;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cfls_channels.sv
// Valid/ready channel interfaces for frame words and result words.
// Depends on cfls_pkg.
`default_nettype none

interface cfls_req_if;
   import cfls_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] frame_header;
   logic [ByteWidth-1:0] status_byte;
   logic [ByteWidth-1:0] level_one;
   logic [ByteWidth-1:0] level_two;
   logic [ByteWidth-1:0] check_byte;
   logic [ByteWidth-1:0] local_level;

   modport source (
      output valid, frame_header, status_byte, level_one, level_two, check_byte,
             local_level,
      input  ready
   );

   modport sink (
      input  valid, frame_header, status_byte, level_one, level_two, check_byte,
             local_level,
      output ready
   );
endinterface

interface cfls_rsp_if;
   import cfls_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 link_ok;
   logic                 mute;
   logic                 pot_write;
   logic [ByteWidth-1:0] pot_level;

   modport source (
      output valid, link_ok, mute, pot_write, pot_level,
      input  ready
   );

   modport sink (
      input  valid, link_ok, mute, pot_write, pot_level,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/checked_frame_level_selector.sv
// Top level of the checked frame level selector: input and result
// registers, stored levels, and the register block.
// Depends on cfls_pkg, cfls_channels, cfls_csr, cfls_eval, assert_macros.svh.
//
// Usage:
//   req_ch carries one polled pedal frame plus the local knob sample per
//   word; rsp_ch returns one word per frame: link_ok, mute, pot_write and
//   pot_level (zero when no write is due).
//   A frame word is taken into the input register, evaluated against the
//   stored levels as it moves to the result register, and shown on rsp_ch
//   from the result register. One word is taken per cycle while the
//   receiver keeps rsp_ch.ready high; the rate is set by the single
//   evaluation path.
//   When the receiver stalls, the result register holds its word and the
//   input register holds one more; req_ch.ready falls once both are full
//   and rises again in the cycle the receiver takes the result.
//   Reset (synchronous, active high) empties both registers, clears the
//   stored levels and sets expected_header to 0 and on_bit_mask to 1.
//   Registers are written over the csr_ port at byte addresses 0 and 4;
//   the user must write them only while the block is idle, as the block does not enforce it.
`default_nettype none

`include "assert_macros.svh"

module checked_frame_level_selector (
   input  wire logic                              clock,
   input  wire logic                              reset,
   cfls_req_if.sink                               req_ch,
   cfls_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cfls_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [cfls_pkg::CsrDataWidth-1:0] csr_pwdata,
   output      logic [cfls_pkg::CsrDataWidth-1:0] csr_prdata,
   output      logic                              csr_pready
);
   import cfls_pkg::*;

   cfg_type         cfg;
   logic            in_valid_ff;
   logic            in_valid_in;
   req_word_type    in_word_ff;
   req_word_type    in_word_in;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_word_type    out_word_ff;
   rsp_word_type    out_word_in;
   level_state_type levels_ff;
   level_state_type levels_in;
   level_state_type levels_next;
   rsp_word_type    result;
   req_word_type    req_word;
   logic            out_free;
   logic            advance;
   logic            accept;

   cfls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cfls_eval u_eval (
      .word        (in_word_ff),
      .cfg         (cfg),
      .levels      (levels_ff),
      .result      (result),
      .levels_next (levels_next)
   );

   // gather the incoming word
   assign req_word.frame_header = req_ch.frame_header;
   assign req_word.status_byte  = req_ch.status_byte;
   assign req_word.level_one    = req_ch.level_one;
   assign req_word.level_two    = req_ch.level_two;
   assign req_word.check_byte   = req_ch.check_byte;
   assign req_word.local_level  = req_ch.local_level;

   // handshake: advance the held word when the result slot frees up
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      levels_in    = levels_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_word_in = result;
         levels_in   = levels_next;
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         levels_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         levels_ff    <= levels_in;
      end
   end

   // payload registers hold without reset
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   // drive the result channel
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.link_ok   = out_word_ff.link_ok;
   assign rsp_ch.mute      = out_word_ff.mute;
   assign rsp_ch.pot_write = out_word_ff.pot_write;
   assign rsp_ch.pot_level = out_word_ff.pot_level;

   // no level is shown without a write, and a broken link never mutes
   `ASSERT_IMPLY(a_level_zero, clock, reset, out_valid_ff && !out_word_ff.pot_write, out_word_ff.pot_level == '0)
   `ASSERT_IMPLY(a_unmute_bad, clock, reset, out_valid_ff && !out_word_ff.link_ok, !out_word_ff.mute)
   // an empty result slot never blocks the input
   `ASSERT_IMPLY(a_ready_free, clock, reset, !out_valid_ff, req_ch.ready)
   // a word held at the input reaches the result slot when it is free
   `ASSERT_NEXT(a_advance, clock, reset, advance, out_valid_ff)
   // stored levels change only when a word advances
   `ASSERT_NEXT(a_levels_hold, clock, reset, !advance, $stable(levels_ff))

endmodule

`default_nettype wire

// File: hw/rtl/cfls_csr.sv
// APB-style register block: expected header and on-bit mask.
// Depends on cfls_pkg.
`default_nettype none

module cfls_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cfls_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [cfls_pkg::CsrDataWidth-1:0] csr_pwdata,
   output      logic [cfls_pkg::CsrDataWidth-1:0] csr_prdata,
   output      logic                              csr_pready,
   output      cfls_pkg::cfg_type                 cfg
);
   import cfls_pkg::*;

   logic [ByteWidth-1:0] header_ff;
   logic [ByteWidth-1:0] header_in;
   logic [ByteWidth-1:0] mask_ff;
   logic [ByteWidth-1:0] mask_in;
   logic                 wr_en;
   reg_index_type        index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = reg_index_type'(csr_paddr[2]);

   // select next register values on a completed write
   always_comb begin
      header_in = header_ff;
      mask_in   = mask_ff;
      if (wr_en) begin
         case (index)
            REG_EXPECTED_HEADER: header_in = csr_pwdata[ByteWidth-1:0];
            REG_ON_BIT_MASK:     mask_in   = csr_pwdata[ByteWidth-1:0];
            default: begin
               header_in = header_ff;
               mask_in   = mask_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HeaderReset;
         mask_ff   <= OnMaskReset;
      end else begin
         header_ff <= header_in;
         mask_ff   <= mask_in;
      end
   end

   // read back the addressed register
   always_comb begin
      case (index)
         REG_EXPECTED_HEADER: csr_prdata = {{(CsrDataWidth-ByteWidth){1'b0}}, header_ff};
         REG_ON_BIT_MASK:     csr_prdata = {{(CsrDataWidth-ByteWidth){1'b0}}, mask_ff};
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.expected_header = header_ff;
   assign cfg.on_bit_mask     = mask_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cfls_eval.sv
// Frame check and level selection for one held frame word.
// Depends on cfls_pkg; purely combinational.
`default_nettype none

module cfls_eval (
   input  wire cfls_pkg::req_word_type    word,
   input  wire cfls_pkg::cfg_type         cfg,
   input  wire cfls_pkg::level_state_type levels,
   output      cfls_pkg::rsp_word_type    result,
   output      cfls_pkg::level_state_type levels_next
);
   import cfls_pkg::*;

   logic [ByteWidth-1:0] crc;
   logic                 ok;
   logic                 wr;
   logic [ByteWidth-1:0] lvl;

   assign crc = crc_three(word.status_byte, word.level_one, word.level_two);
   assign ok  = (word.frame_header == cfg.expected_header) && (crc == word.check_byte);

   // pick the level and update the stored copies
   always_comb begin
      levels_next = levels;
      wr          = 1'b0;
      lvl         = '0;
      if (ok) begin
         if ((word.status_byte & SelectTwoMask) != '0) begin
            if (word.level_two != levels.last_pedal_two) begin
               wr  = 1'b1;
               lvl = word.level_two;
            end
         end else begin
            if (word.level_one != levels.last_pedal_one) begin
               wr  = 1'b1;
               lvl = word.level_one;
            end
         end
         levels_next.last_pedal_one = word.level_one;
         levels_next.last_pedal_two = word.level_two;
      end else begin
         if (word.local_level != levels.last_local) begin
            wr  = 1'b1;
            lvl = word.local_level;
         end
         levels_next.last_local = word.local_level;
      end
   end

   assign result.link_ok   = ok;
   assign result.mute      = ok && ((word.status_byte & cfg.on_bit_mask) == '0);
   assign result.pot_write = wr;
   assign result.pot_level = lvl;

endmodule

`default_nettype wire

// File: bench/cfls_level_checker.sv
`timescale 1ns / 1ps
// Checker for the frame level selector: follows register writes, predicts each
// result word from the frame words taken in, and compares the result words.
// Depends on cfls_pkg and the channel interfaces in cfls_channels.

module cfls_level_checker
   import cfls_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   cfls_req_if                     req_ch,
   cfls_rsp_if                     rsp_ch,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic                    csr_pready,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output int                      mismatch_count,
   output int                      results_due
);

   cfg_type         cfg_now;
   level_state_type levels;
   rsp_word_type    pot_updates_due[$];

   // CRC-8 over status, level one and level two, one bit at a time, MSB first
   function automatic logic [ByteWidth-1:0] payload_crc(input logic [ByteWidth-1:0] st,
                                                        input logic [ByteWidth-1:0] l1,
                                                        input logic [ByteWidth-1:0] l2);
      logic [3*ByteWidth-1:0] bits;
      logic [ByteWidth-1:0]   crc;
      logic                   feedback;
      bits = {st, l1, l2};
      crc  = CrcInit;
      for (int i = 3*ByteWidth-1; i >= 0; i--) begin
         feedback = crc[ByteWidth-1] ^ bits[i];
         crc = crc << 1;
         if (feedback) begin
            crc = crc ^ CrcPoly;
         end
      end
      return crc;
   endfunction

   // Work out the result word of one frame and advance the stored levels
   task automatic predict_pot_update(input req_word_type f, output rsp_word_type r);
      logic [ByteWidth-1:0] chosen;
      logic [ByteWidth-1:0] stored;
      r = '0;
      r.link_ok = (f.frame_header == cfg_now.expected_header) &&
                  (payload_crc(f.status_byte, f.level_one, f.level_two) == f.check_byte);
      if (r.link_ok) begin
         r.mute = (f.status_byte & cfg_now.on_bit_mask) == '0;
         if ((f.status_byte & SelectTwoMask) != '0) begin
            chosen = f.level_two;
            stored = levels.last_pedal_two;
         end else begin
            chosen = f.level_one;
            stored = levels.last_pedal_one;
         end
         levels.last_pedal_one = f.level_one;
         levels.last_pedal_two = f.level_two;
      end else begin
         // broken link falls back to the local knob, never muted
         chosen = f.local_level;
         stored = levels.last_local;
         levels.last_local = f.local_level;
      end
      if (chosen != stored) begin
         r.pot_write = 1'b1;
         r.pot_level = chosen;
      end
   endtask

   // Compare one result word with the oldest prediction
   task automatic compare_pot_update(input rsp_word_type got);
      rsp_word_type due;
      if (pot_updates_due.size() == 0) begin
         $error("result word with no prediction waiting");
         mismatch_count++;
      end else begin
         due = pot_updates_due.pop_front();
         if (got.link_ok !== due.link_ok) begin
            $error("link_ok: expected %0d, got %0d", due.link_ok, got.link_ok);
            mismatch_count++;
         end
         if (got.mute !== due.mute) begin
            $error("mute: expected %0d, got %0d", due.mute, got.mute);
            mismatch_count++;
         end
         if (got.pot_write !== due.pot_write) begin
            $error("pot_write: expected %0d, got %0d", due.pot_write, got.pot_write);
            mismatch_count++;
         end
         if (got.pot_level !== due.pot_level) begin
            $error("pot_level: expected %0h, got %0h", due.pot_level, got.pot_level);
            mismatch_count++;
         end
      end
   endtask

   // Sample all channels at the rising edge
   always @(posedge clock) begin
      req_word_type frame;
      rsp_word_type seen;
      rsp_word_type predicted;
      if (reset) begin
         cfg_now.expected_header = HeaderReset;
         cfg_now.on_bit_mask     = OnMaskReset;
         levels                  = '0;
         pot_updates_due.delete();
         mismatch_count          = 0;
      end else begin
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CsrAddrWidth-1:2]))
               REG_EXPECTED_HEADER: begin
                  cfg_now.expected_header = csr_pwdata[ByteWidth-1:0];
               end
               REG_ON_BIT_MASK: begin
                  cfg_now.on_bit_mask = csr_pwdata[ByteWidth-1:0];
               end
               default: begin
               end
            endcase
         end
         // check the result word before pushing a new prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = {rsp_ch.link_ok, rsp_ch.mute, rsp_ch.pot_write, rsp_ch.pot_level};
            compare_pot_update(seen);
         end
         if (req_ch.valid && req_ch.ready) begin
            frame = {req_ch.frame_header, req_ch.status_byte, req_ch.level_one,
                     req_ch.level_two, req_ch.check_byte, req_ch.local_level};
            predict_pot_update(frame, predicted);
            pot_updates_due.push_back(predicted);
         end
      end
      results_due = pot_updates_due.size();
   end

endmodule

// File: bench/checked_frame_level_selector_tb.sv
`timescale 1ns / 1ps
// Testbench top for the frame level selector: clock, reset, frame and register
// stimulus, random stalls on both channels, watchdog and verdict.
// Depends on cfls_pkg, cfls_channels, the block itself and cfls_level_checker.

module checked_frame_level_selector_tb;
   import cfls_pkg::*;

   localparam int ResetCycles    = 10;
   localparam int PhaseCount     = 7;
   localparam int RandomPerPhase = 233;
   localparam int SettleCycles   = 4;
   localparam int LongHold       = 80;
   localparam int QuietLimit     = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfls_req_if req_ch ();
   cfls_rsp_if rsp_ch ();

   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   int mismatch_count;
   int results_due;
   int quiet_cycles = 0;

   logic                 req_taken = 1'b0;
   bit                   long_hold_due = 1'b0;
   bit                   steady_send = 1'b0;
   bit                   steady_take = 1'b0;
   logic [ByteWidth-1:0] cfg_header = HeaderReset;

   // header/mask pairs per phase; phase 0 runs on the reset values
   logic [ByteWidth-1:0] phase_header[PhaseCount];
   logic [ByteWidth-1:0] phase_mask[PhaseCount];

   always #5 clock = ~clock;

   checked_frame_level_selector u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cfls_level_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   // Remember whether the frame word on offer was taken at this edge
   always @(posedge clock) begin
      req_taken <= req_ch.valid && req_ch.ready;
   end

   // End the run when no word moves for too long
   always @(posedge clock) begin
      if (quiet_cycles >= QuietLimit) begin
         $display("Verification failed");
         $finish;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int idle_cycles(input bit steady);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (steady || pick < 60) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Knob levels from a small pool half the time so that repeats are common
   function automatic logic [ByteWidth-1:0] knob_sample();
      if ($urandom_range(0, 1) == 1) begin
         return ByteWidth'($urandom_range(0, 3));
      end
      return ByteWidth'($urandom_range(0, 255));
   endfunction

   // Frame word that passes the header and check byte tests
   function automatic req_word_type good_frame(input logic [ByteWidth-1:0] st,
                                               input logic [ByteWidth-1:0] l1,
                                               input logic [ByteWidth-1:0] l2,
                                               input logic [ByteWidth-1:0] loc);
      req_word_type f;
      f.frame_header = cfg_header;
      f.status_byte  = st;
      f.level_one    = l1;
      f.level_two    = l2;
      f.check_byte   = crc_three(st, l1, l2);
      f.local_level  = loc;
      return f;
   endfunction

   // Offer one frame word after a random gap; return once it is taken
   task automatic send_frame(input req_word_type f);
      int gap;
      gap = idle_cycles(steady_send);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.frame_header, req_ch.status_byte, req_ch.level_one, req_ch.level_two,
       req_ch.check_byte, req_ch.local_level} <= f;
      do @(negedge clock); while (!req_taken);
   endtask

   // Setup cycle, then access cycle
   task automatic write_reg(input reg_index_type idx, input logic [ByteWidth-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'($urandom()), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Drop valid and wait until every predicted word has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Receiver: random stalls, long hold-off on request
   initial begin
      int hold;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold = LongHold;
         end else begin
            hold = idle_cycles(steady_take);
         end
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) begin
            steady_take = !steady_take;
         end
      end
   end

   // Sender: directed frames, then random phases under several settings
   initial begin
      req_word_type f;
      int           n;
      int unsigned  kind;

      req_ch.valid        = 1'b0;
      req_ch.frame_header = '0;
      req_ch.status_byte  = '0;
      req_ch.level_one    = '0;
      req_ch.level_two    = '0;
      req_ch.check_byte   = '0;
      req_ch.local_level  = '0;
      rsp_ch.ready        = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;

      phase_header = '{8'h00, 8'hFF, 8'h5A, 8'h00, 8'hC3, 8'h00, 8'h00};
      phase_mask   = '{8'h01, 8'hFF, 8'h00, 8'h80, 8'h02, 8'h00, 8'h00};
      phase_header[5] = ByteWidth'($urandom_range(0, 255));
      phase_mask[5]   = ByteWidth'($urandom_range(1, 255));
      phase_header[6] = ByteWidth'($urandom_range(0, 255));
      phase_mask[6]   = ByteWidth'($urandom_range(1, 255));

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all-zero valid frame: muted, level unchanged so no write
      send_frame(good_frame(8'h00, 8'h00, 8'h00, 8'h00));
      // on bit set, level one changes
      send_frame(good_frame(8'h01, 8'hFF, 8'h00, 8'h00));
      // select level two, which changes
      send_frame(good_frame(8'h03, 8'hFF, 8'hFF, 8'h00));
      // same frame again: nothing changed
      send_frame(good_frame(8'h03, 8'hFF, 8'hFF, 8'h00));
      // level two selected and unchanged, muted
      send_frame(good_frame(8'h02, 8'hFF, 8'hFF, 8'h00));
      // write of level zero
      send_frame(good_frame(8'h00, 8'h00, 8'hFF, 8'h00));
      // all status bits set; local knob moves but a valid frame ignores it
      send_frame(good_frame(8'hFF, 8'hFF, 8'h00, 8'hFF));
      // wrong header: local level written
      f = good_frame(8'h01, 8'h12, 8'h34, 8'hFF);
      f.frame_header = 8'hFF;
      send_frame(f);
      send_frame(f);
      // bad check byte: local level back to zero, pedal levels kept
      f = good_frame(8'h01, 8'h10, 8'h20, 8'h00);
      f.check_byte = f.check_byte ^ 8'h80;
      send_frame(f);
      // pedal level one unchanged since the last valid frame
      send_frame(good_frame(8'h01, 8'hFF, 8'h00, 8'hAA));
      // all-ones and all-zero broken frames
      send_frame('1);
      f = '0;
      f.check_byte = 8'hFF;
      send_frame(f);
      send_frame(good_frame(8'hFE, 8'h7F, 8'h80, 8'h01));
      send_frame(good_frame(8'h7D, 8'h80, 8'h7F, 8'h80));
      f = good_frame(8'h55, 8'hAA, 8'h55, 8'hAA);
      f.frame_header = 8'h01;
      send_frame(f);

      n = 0;
      for (int p = 0; p < PhaseCount; p++) begin
         if (p > 0) begin
            drain();
            write_reg(REG_EXPECTED_HEADER, phase_header[p]);
            write_reg(REG_ON_BIT_MASK, phase_mask[p]);
            cfg_header = phase_header[p];
            // a few fixed frames under each new setting
            send_frame(good_frame(8'h01, 8'h00, 8'h00, 8'h00));
            send_frame(good_frame(8'h82, 8'hFF, 8'hFF, 8'hFF));
         end
         for (int i = 0; i < RandomPerPhase; i++) begin
            f = good_frame(ByteWidth'($urandom_range(0, 255)), knob_sample(), knob_sample(),
                           knob_sample());
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
               f.frame_header = f.frame_header ^ ByteWidth'($urandom_range(1, 255));
            end else if (kind < 24) begin
               f.check_byte = f.check_byte ^ ByteWidth'($urandom_range(1, 255));
            end else if (kind < 30) begin
               f = req_word_type'({$urandom(), 16'($urandom())});
            end
            if (n % 500 == 250) begin
               long_hold_due = 1'b1;
            end
            if ($urandom_range(0, 63) == 0) begin
               steady_send = !steady_send;
            end
            send_frame(f);
            n++;
         end
      end

      drain();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/cfls_pkg.sv
hw/rtl/cfls_channels.sv
hw/rtl/cfls_csr.sv
hw/rtl/cfls_eval.sv
hw/rtl/checked_frame_level_selector.sv
bench/cfls_level_checker.sv
bench/checked_frame_level_selector_tb.sv
